FILE: rtl/lge_pkg.sv
// ----------------------------------------------------------------------------
// lge_pkg
// Shared types and constants of the life generation engine.
// ----------------------------------------------------------------------------
package lge_pkg;

  localparam int unsigned MaxSide = 64;
  localparam int unsigned SideW   = $clog2(MaxSide) + 1;
  localparam int unsigned IdxW    = $clog2(MaxSide);

  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_ADVANCE = 2'd2;

  localparam logic [SideW-1:0] SIDE_RESET = SideW'(MaxSide);

  typedef logic [MaxSide-1:0] row_t;

  typedef struct packed {
    logic [1:0]      action;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
    logic            alive_in;
  } in_word_t;

  typedef struct packed {
    logic alive_out;
    logic status;
  } out_word_t;

  typedef struct packed {
    logic capture;
    logic rd_cell;
    logic wr_cell;
    logic adv_start;
    logic adv_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic cell_ok;
    logic act_write;
    logic act_advance;
    logic side_zero;
    logic sweep_last;
  } sts_t;

endpackage

FILE: rtl/lge_ctrl.sv
// ----------------------------------------------------------------------------
// lge_ctrl
// Controller: sequences one word through decode, cell access or row sweep,
// and result hand-off.
// ----------------------------------------------------------------------------
module lge_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          out_free_i,
  input  lge_pkg::sts_t sts_i,
  output logic          in_stall_o,
  output lge_pkg::cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECODE = 5'b00010,
    ST_MODIFY = 5'b00100,
    ST_SWEEP  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts_i.cell_ok) begin
          cmd_o.rd_cell = 1'b1;
          state_d       = ST_MODIFY;
        end else if (sts_i.act_advance && !sts_i.side_zero) begin
          cmd_o.adv_start = 1'b1;
          state_d         = ST_SWEEP;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_MODIFY: begin
        cmd_o.wr_cell = sts_i.act_write;
        state_d       = ST_FINISH;
      end
      ST_SWEEP: begin
        cmd_o.adv_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> out_free_i)
    else $error("result loaded while output word still held");

  a_accept_to_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_DECODE))
    else $error("accepted word not decoded");

  a_cell_write_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_cell |-> (sts_i.act_write && sts_i.cell_ok))
    else $error("cell write for a word that is not an in-range write");

  a_sweep_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP && sts_i.sweep_last) |=> (state_q == ST_FINISH))
    else $error("sweep did not end after last row");

endmodule

FILE: rtl/lge_datapath.sv
// ----------------------------------------------------------------------------
// lge_datapath
// Grid memory with per-row valid bits, three-row window and the B3/S23
// next-row logic, plus the held word and its result fields.
// ----------------------------------------------------------------------------
module lge_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lge_pkg::cmd_t                   cmd_i,
  input  lge_pkg::in_word_t               in_word_i,
  input  logic [lge_pkg::SideW-1:0]       grid_side_i,
  output lge_pkg::sts_t                   sts_o,
  output lge_pkg::out_word_t              res_o
);

  localparam int unsigned Depth = lge_pkg::MaxSide;
  localparam int unsigned SideW = lge_pkg::SideW;
  localparam int unsigned IdxW  = lge_pkg::IdxW;

  function automatic lge_pkg::row_t life_row(lge_pkg::row_t above, lge_pkg::row_t cur,
                                             lge_pkg::row_t below, lge_pkg::row_t mask);
    lge_pkg::row_t al, ar, cl, cr, bl, br, nxt;
    logic [3:0]    n;
    al = above << 1;
    ar = above >> 1;
    cl = cur << 1;
    cr = cur >> 1;
    bl = below << 1;
    br = below >> 1;
    nxt = '0;
    for (int c = 0; c < Depth; c++) begin
      n = {3'b0, al[c]} + {3'b0, above[c]} + {3'b0, ar[c]} + {3'b0, cl[c]} +
          {3'b0, cr[c]} + {3'b0, bl[c]} + {3'b0, below[c]} + {3'b0, br[c]};
      nxt[c] = (n == 4'd3) || (cur[c] && (n == 4'd2));
    end
    return nxt & mask;
  endfunction

  lge_pkg::row_t     mem_q [Depth];
  lge_pkg::row_t     rd_data_q;
  logic              rd_valid_q;
  logic [Depth-1:0]  row_valid_q;
  lge_pkg::in_word_t item_q;
  lge_pkg::row_t     above_q, cur_q;
  logic [SideW-1:0]  sweep_q;

  logic [SideW-1:0]  side;
  lge_pkg::row_t     mask, rd_row, below, cell_row, next_row, wr_data;
  logic              act_cell, cell_ok, have_below, rd_en, wr_en;
  logic [IdxW-1:0]   rd_addr, wr_addr;
  logic [SideW-1:0]  wr_sweep;

  assign side = (grid_side_i > lge_pkg::SIDE_RESET) ? lge_pkg::SIDE_RESET : grid_side_i;
  assign mask = (side >= SideW'(Depth)) ? '1 : ((lge_pkg::row_t'(1) << side) - 1'b1);

  assign act_cell = (item_q.action inside {lge_pkg::ACT_WRITE, lge_pkg::ACT_READ});
  assign cell_ok  = act_cell && ({1'b0, item_q.row} < side) && ({1'b0, item_q.col} < side);

  assign rd_row     = rd_valid_q ? rd_data_q : '0;
  assign have_below = (sweep_q != '0) && (sweep_q <= side);
  assign below      = have_below ? (rd_row & mask) : '0;
  assign next_row   = life_row(above_q, cur_q, below, mask);
  assign wr_sweep   = sweep_q - SideW'(2);

  always_comb begin
    cell_row = rd_row;
    cell_row[item_q.col] = item_q.alive_in;
  end

  assign rd_en   = cmd_i.rd_cell || (cmd_i.adv_step && (sweep_q < side));
  assign rd_addr = cmd_i.adv_step ? sweep_q[IdxW-1:0] : item_q.row;
  assign wr_en   = cmd_i.wr_cell || (cmd_i.adv_step && (sweep_q >= SideW'(2)));
  assign wr_addr = cmd_i.wr_cell ? item_q.row : wr_sweep[IdxW-1:0];
  assign wr_data = cmd_i.wr_cell ? cell_row : next_row;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q  <= mem_q[rd_addr];
      rd_valid_q <= row_valid_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      sweep_q     <= '0;
    end else begin
      if (cmd_i.adv_start) begin
        sweep_q <= '0;
        for (int i = 0; i < Depth; i++) begin
          if (SideW'(i) >= side) begin
            row_valid_q[i] <= 1'b0;
          end
        end
      end else if (cmd_i.adv_step) begin
        sweep_q <= sweep_q + 1'b1;
      end
      if (wr_en) begin
        row_valid_q[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_word_i;
    end
    if (cmd_i.adv_start) begin
      above_q <= '0;
      cur_q   <= '0;
    end else if (cmd_i.adv_step && (sweep_q != '0)) begin
      above_q <= cur_q;
      cur_q   <= below;
    end
  end

  assign sts_o.cell_ok     = cell_ok;
  assign sts_o.act_write   = (item_q.action == lge_pkg::ACT_WRITE);
  assign sts_o.act_advance = (item_q.action == lge_pkg::ACT_ADVANCE);
  assign sts_o.side_zero   = (side == '0);
  assign sts_o.sweep_last  = ({1'b0, sweep_q} == ({1'b0, side} + 1'b1));

  assign res_o.alive_out = (item_q.action == lge_pkg::ACT_READ) && cell_ok && rd_row[item_q.col];
  assign res_o.status    = act_cell && !cell_ok;

endmodule

FILE: rtl/life_generation_engine.sv
// ----------------------------------------------------------------------------
// life_generation_engine
// Square B3/S23 cellular automaton grid with cell write, cell read and
// one-generation advance; side register and output word register.
//
//   channel   handshake              payload
//   in        in_valid_i / in_stall_o  in_word_i  (action, row, col, alive_in)
//   out       out_valid_o / out_stall_i out_word_o (alive_out, status)
//   cfg       cfg_valid_i / cfg_ready_o cfg_data_i (grid_side)
//
// Cell accesses in range pass decode, modify and finish; others skip modify.
// Advance sweeps the grid: the row sweep reads one grid row per cycle
// and writes back the row two behind it, plus window fill and drain.
// One word is in work at a time; a held result does not block acceptance.
// Reset clears all rows to dead through per-row valid bits, no clearing pass.
// ----------------------------------------------------------------------------
module life_generation_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  lge_pkg::in_word_t           in_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output lge_pkg::out_word_t          out_word_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lge_pkg::SideW-1:0]   cfg_data_i
);

  lge_pkg::cmd_t             cmd;
  lge_pkg::sts_t             sts;
  lge_pkg::out_word_t        res;
  logic [lge_pkg::SideW-1:0] grid_side_q;
  logic                      out_valid_q;
  lge_pkg::out_word_t        out_word_q;
  logic                      out_free;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_side_q <= lge_pkg::SIDE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        grid_side_q <= cfg_data_i;
      end
      if (cmd.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  lge_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  lge_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_word_i   (in_word_i),
    .grid_side_i (grid_side_q),
    .sts_o       (sts),
    .res_o       (res)
  );

endmodule

FILE: dv/life_generation_engine_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// life_generation_engine_checker
// Watches the input, output and side-register channels of the life engine.
// It keeps its own copy of the grid and the side, predicts the result word of
// every accepted input word under B3/S23, and compares each accepted output
// word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module life_generation_engine_checker
  import lge_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  in_word_t         in_word_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  out_word_t        out_word_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [SideW-1:0] cfg_data_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               results_o
);

  row_t             cells [MaxSide];
  logic [SideW-1:0] side_reg;
  out_word_t        due_words [$];

  function automatic int live_side();
    return (side_reg > MaxSide) ? MaxSide : int'(side_reg);
  endfunction

  function automatic int cell_at(input row_t v, input int c, input int s);
    if (c < 0 || c >= s) return 0;
    return int'(v[c]);
  endfunction

  function automatic void advance_cells();
    int   s;
    int   n;
    row_t mask;
    row_t above;
    row_t cur;
    row_t below;
    row_t nxt;
    s = live_side();
    if (s == 0) return;
    mask  = (s >= MaxSide) ? '1 : ((row_t'(1) << s) - row_t'(1));
    above = '0;
    for (int r = 0; r < MaxSide; r++) begin
      if (r >= s) begin
        cells[r] = '0;
        continue;
      end
      cur   = cells[r] & mask;
      below = (r + 1 < s) ? (cells[r + 1] & mask) : '0;
      nxt   = '0;
      for (int c = 0; c < s; c++) begin
        n = cell_at(above, c - 1, s) + cell_at(above, c, s) + cell_at(above, c + 1, s) +
            cell_at(cur, c - 1, s) + cell_at(cur, c + 1, s) +
            cell_at(below, c - 1, s) + cell_at(below, c, s) + cell_at(below, c + 1, s);
        if (n == 3 || (cur[c] && n == 2)) nxt[c] = 1'b1;
      end
      cells[r] = nxt;
      above    = cur;
    end
  endfunction

  function automatic out_word_t predict_word(input in_word_t w);
    out_word_t res;
    int        s;
    s   = live_side();
    res = '0;
    case (w.action)
      ACT_WRITE, ACT_READ: begin
        if (w.row >= s || w.col >= s) begin
          res.status = 1'b1;
        end else if (w.action == ACT_WRITE) begin
          cells[w.row][w.col] = w.alive_in;
        end else begin
          res.alive_out = cells[w.row][w.col];
        end
      end
      ACT_ADVANCE: begin
        advance_cells();
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i) begin
    out_word_t want;
    if (!rst_ni) begin
      for (int r = 0; r < MaxSide; r++) cells[r] = '0;
      side_reg = SIDE_RESET;
      due_words.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_words.size() == 0) begin
          fail_count_o++;
          $error("result word with nothing expected: alive_out %0b, status %0b",
                 out_word_i.alive_out, out_word_i.status);
        end else begin
          want = due_words.pop_front();
          results_o++;
          if (out_word_i.alive_out !== want.alive_out) begin
            fail_count_o++;
            $error("alive_out mismatch: expected %0b, actual %0b",
                   want.alive_out, out_word_i.alive_out);
          end
          if (out_word_i.status !== want.status) begin
            fail_count_o++;
            $error("status mismatch: expected %0b, actual %0b",
                   want.status, out_word_i.status);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) side_reg = cfg_data_i;
      if (in_valid_i && !in_stall_i) due_words.push_back(predict_word(in_word_i));
    end
    pending_o = due_words.size();
  end

endmodule

FILE: dv/life_generation_engine_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// life_generation_engine_test
// Drives the life engine with directed cell writes, reads and generation
// advances at grid edges and side extremes, then random phases over many
// grid sides and idle/stall mixes. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module life_generation_engine_test;
  import lge_pkg::*;

  localparam logic [1:0] ActUnused  = 2'd3;
  localparam int         QuietLimit = 4000;
  localparam int         PhaseWords = 112;
  localparam int         EndDrain   = 80;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_word_t         in_word   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_word_t        out_word;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [SideW-1:0] cfg_data  = '0;

  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;
  logic cfg_taken = 1'b0;

  int fail_count;
  int pending;
  int results;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int words_sent    = 0;
  int side_writes   = 0;
  int side_now      = MaxSide;
  int hot_base      = 0;

  life_generation_engine uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  life_generation_engine_checker life_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_word_i   (out_word),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    in_taken  <= in_valid && !in_stall;
    out_taken <= out_valid && !out_stall;
    cfg_taken <= cfg_valid && cfg_ready;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic in_word_t mk_word(input logic [1:0] act, input int r, input int c,
                                       input logic v);
    in_word_t w;
    w.action   = act;
    w.row      = IdxW'(r);
    w.col      = IdxW'(c);
    w.alive_in = v;
    return w;
  endfunction

  function automatic int pick_index();
    if (side_now == 0) return $urandom_range(0, MaxSide - 1);
    if ($urandom_range(0, 1) == 0) return (hot_base + $urandom_range(0, 7)) % side_now;
    return $urandom_range(0, side_now - 1);
  endfunction

  function automatic in_word_t random_word();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return mk_word(ACT_WRITE, pick_index(), pick_index(),
                                  $urandom_range(0, 9) < 6);
    if (roll < 80) return mk_word(ACT_READ, pick_index(), pick_index(),
                                  1'($urandom_range(0, 1)));
    if (roll < 91) return mk_word(ACT_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63),
                                  1'($urandom_range(0, 1)));
    if (roll < 94) return mk_word(ActUnused, $urandom_range(0, 63), $urandom_range(0, 63),
                                  1'($urandom_range(0, 1)));
    return mk_word($urandom_range(0, 1) ? ACT_WRITE : ACT_READ, $urandom_range(0, 63),
                   $urandom_range(0, 63), 1'($urandom_range(0, 1)));
  endfunction

  task automatic send_word(input in_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(negedge clk); while (!in_taken);
    words_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_side(input logic [SideW-1:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
    side_now = (v > MaxSide) ? MaxSide : int'(v);
    side_writes++;
  endtask

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(negedge clk);
      if (in_taken || out_taken || cfg_taken) quiet = 0;
      else quiet++;
    end
    $display("Watchdog: no word moved for %0d cycles", QuietLimit);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int sides [12];
    sides = '{6, 64, 1, 10, 3, 127, 16, 2, 64, 9, 65, 4};
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // corners at the reset side, then blinkers on the top and bottom edges
    send_word(mk_word(ACT_WRITE, 0, 0, 1'b1));
    send_word(mk_word(ACT_WRITE, 63, 63, 1'b1));
    send_word(mk_word(ACT_READ, 0, 0, 1'b0));
    send_word(mk_word(ACT_READ, 63, 63, 1'b1));
    send_word(mk_word(ACT_READ, 0, 63, 1'b0));
    send_word(mk_word(ACT_WRITE, 0, 1, 1'b1));
    send_word(mk_word(ACT_WRITE, 0, 2, 1'b1));
    send_word(mk_word(ACT_WRITE, 63, 61, 1'b1));
    send_word(mk_word(ACT_WRITE, 63, 62, 1'b1));
    send_word(mk_word(ACT_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63),
                      1'($urandom_range(0, 1))));
    send_word(mk_word(ACT_READ, 1, 1, 1'b0));
    send_word(mk_word(ACT_READ, 0, 0, 1'b0));
    send_word(mk_word(ACT_READ, 62, 62, 1'b0));
    send_word(mk_word(ActUnused, 63, 63, 1'b1));

    // shrink: advance clears cells beyond the side
    write_side(SideW'(3));
    send_word(mk_word(ACT_ADVANCE, 0, 0, 1'b0));
    send_word(mk_word(ACT_READ, 3, 0, 1'b0));
    send_word(mk_word(ACT_WRITE, 0, 5, 1'b1));
    send_word(mk_word(ACT_READ, 1, 1, 1'b0));
    write_side(SideW'(MaxSide));
    send_word(mk_word(ACT_READ, 62, 62, 1'b0));
    send_word(mk_word(ACT_READ, 63, 63, 1'b0));

    // empty grid
    write_side('0);
    send_word(mk_word(ACT_READ, 0, 0, 1'b0));
    send_word(mk_word(ACT_WRITE, 0, 0, 1'b1));
    send_word(mk_word(ACT_ADVANCE, 0, 0, 1'b0));

    // oversized side acts as the maximum
    write_side('1);
    send_word(mk_word(ACT_READ, 63, 63, 1'b0));

    for (int p = 0; p < 12; p++) begin
      write_side(SideW'(sides[p]));
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 88;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 88;
        end
        default: begin
          send_idle_pct = 35;
          stall_pct     = 35;
        end
      endcase
      hot_base = $urandom_range(0, MaxSide - 1);
      for (int k = 0; k < PhaseWords; k++) begin
        if (p == 1 && k == PhaseWords / 2) drain_results();
        send_word(random_word());
      end
    end

    drain_results();
    repeat (EndDrain) @(negedge clk);
    $display("Sent %0d words across %0d side settings (0, 1..64 and above 64);",
             words_sent, side_writes);
    $display("%0d results checked; writes, reads, advances and unused actions ran %s",
             results, "under four idle and stall mixes.");
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/lge_pkg.sv
rtl/lge_ctrl.sv
rtl/lge_datapath.sv
rtl/life_generation_engine.sv
dv/life_generation_engine_checker.sv
dv/life_generation_engine_test.sv
